>>> hw/rtl/kpr_pkg.sv
// Shared types, constants and helpers for the Kermit packet receiver.
package kpr_pkg;

  // Counter width for byte_count and run_remaining (valid range 7 to 16)
  localparam int CNT_W      = 14;
  // Width of the reported packet length and of max_length
  localparam int LEN_W      = 14;
  // Width used for saturating counter arithmetic before the clamp
  localparam int WIDE_W     = 18;
  // Width used to compare a counter against a 14-bit value
  localparam int CMP_W      = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int HSUM_W     = 11;
  localparam int CTRLC_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  localparam logic [CNT_W-1:0]   CNT_MAX = '1;
  localparam logic [LEN_W-1:0]   LEN_MAX = '1;

  // Byte constants
  localparam logic [7:0] LF_BYTE     = 8'h0a;
  localparam logic [7:0] CTRL_C      = 8'h03;
  localparam logic [6:0] DIGIT_BIAS7 = 7'd32;
  localparam logic [7:0] DIGIT_BIAS  = 8'd32;
  localparam logic [7:0] CHK_BIAS    = 8'd32;
  localparam logic [14:0] HDR_SCALE  = 15'd95;
  // Third consecutive control-C (run count already at this value) is fatal
  localparam logic [CTRLC_W-1:0] CTRLC_LIMIT = 2'd2;

  // Long header field positions, counted in stored bytes
  localparam logic [CNT_W-1:0] HDR_LEN_HI = CNT_W'(3);
  localparam logic [CNT_W-1:0] HDR_LEN_LO = CNT_W'(4);
  localparam logic [CNT_W-1:0] HDR_CHK    = CNT_W'(5);
  localparam logic [CNT_W-1:0] HDR_END    = CNT_W'(6);

  // Register reset values
  localparam logic [7:0]       RST_START_MARK = 8'd1;
  localparam logic [7:0]       RST_END_MARK   = 8'd13;
  localparam logic [LEN_W-1:0] RST_MAX_LENGTH = LEN_W'(90);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MARK   = 3'd0,
    CFG_END_MARK     = 3'd1,
    CFG_MAX_LENGTH   = 3'd2,
    CFG_STRIP_PARITY = 3'd3,
    CFG_REMOTE_MODE  = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_LONG  = 2'd2,
    KIND_FATAL = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0]       start_mark;
    logic [7:0]       end_mark;
    logic [LEN_W-1:0] max_length;
    logic             strip_parity;
    logic             remote_mode;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] packet_length;
  } out_item_t;

  // Clamp a widened count to the counter maximum
  function automatic logic [CNT_W-1:0] sat_cnt(input logic [WIDE_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v > WIDE_W'(CNT_MAX)) ? CNT_MAX : v[CNT_W-1:0];
    return r;
  endfunction

endpackage

>>> hw/rtl/kpr_cfg_regs.sv
// Configuration registers of the Kermit packet receiver.
module kpr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [kpr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kpr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output kpr_pkg::cfg_t                    cfg
);
  import kpr_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Register write decode; unknown indexes are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_START_MARK:   cfg_nxt.start_mark   = cfg_wdata[7:0];
        CFG_END_MARK:     cfg_nxt.end_mark     = cfg_wdata[7:0];
        CFG_MAX_LENGTH:   cfg_nxt.max_length   = cfg_wdata[LEN_W-1:0];
        CFG_STRIP_PARITY: cfg_nxt.strip_parity = cfg_wdata[0];
        CFG_REMOTE_MODE:  cfg_nxt.remote_mode  = cfg_wdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_mark   <= RST_START_MARK;
      cfg_r.end_mark     <= RST_END_MARK;
      cfg_r.max_length   <= RST_MAX_LENGTH;
      cfg_r.strip_parity <= 1'b0;
      cfg_r.remote_mode  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hw/rtl/kpr_in_stage.sv
// Input register stage: holds one received item until it is processed.
module kpr_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kpr_pkg::in_item_t in_data,
  input  logic              slot_free,
  output logic              go,
  output kpr_pkg::in_item_t item
);
  import kpr_pkg::*;

  logic     stage_valid_r, stage_valid_nxt;
  in_item_t stage_item_r;
  logic     accept;

  // Process the held item whenever the result slot can take a result
  assign go       = stage_valid_r && slot_free;
  assign in_stall = stage_valid_r && !slot_free;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (accept) begin
      stage_valid_nxt = 1'b1;
    end else if (go) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_item_r <= in_data;
    end
  end

  assign item = stage_item_r;

endmodule

>>> hw/rtl/kpr_deframe.sv
// Packet state and per-byte deframing logic.
module kpr_deframe (
  input  logic               clk,
  input  logic               rst_n,
  input  kpr_pkg::cfg_t      cfg,
  input  logic               go,
  input  kpr_pkg::in_item_t  item,
  output logic               res_valid,
  output kpr_pkg::out_item_t res
);
  import kpr_pkg::*;

  logic               in_packet_r,   in_packet_nxt;
  logic [CNT_W-1:0]   byte_count_r,  byte_count_nxt;
  logic [CNT_W-1:0]   run_r,         run_nxt;
  logic               long_r,        long_nxt;
  logic [HSUM_W-1:0]  hsum_r,        hsum_nxt;
  logic [CTRLC_W-1:0] ctrlc_r,       ctrlc_nxt;

  logic [7:0]        x, c, run_byte, digit, chk;
  logic [5:0]        chk_low;
  logic [14:0]       hdr_prod;
  logic              bc_zero, len_slot, run_slot, clear;
  logic              run_hdr_long;
  logic [CNT_W-1:0]  run_hdr;
  logic [HSUM_W-1:0] hsum_hdr;
  logic [CMP_W-1:0]  bc_wide;

  // Byte views: parity-stripped compare byte and run byte
  assign x        = item.rx_byte;
  assign c        = cfg.strip_parity ? {1'b0, x[6:0]} : x;
  assign run_byte = c;
  assign digit    = (x < DIGIT_BIAS) ? 8'd0 : (x - DIGIT_BIAS);
  assign hdr_prod = 15'(digit) * HDR_SCALE;
  assign bc_wide  = CMP_W'(byte_count_r);

  assign bc_zero  = (byte_count_r == '0);
  assign len_slot = in_packet_r && bc_zero;
  assign run_slot = in_packet_r && (run_r != '0) && !bc_zero &&
                    !(long_r && (byte_count_r < HDR_END));

  // Header checksum from the running sum
  assign chk_low  = hsum_hdr[5:0] + {4'b0, hsum_hdr[7:6]};
  assign chk      = {2'b00, chk_low} + CHK_BIAS;

  // LEN byte decode and long-header field handling
  always_comb begin
    run_hdr      = run_r;
    run_hdr_long = long_r;
    hsum_hdr     = hsum_r;
    if (len_slot) begin
      if (x[6:0] < DIGIT_BIAS7) begin
        run_hdr = '0;
      end else begin
        run_hdr = CNT_W'(x[6:0] - DIGIT_BIAS7);
        if (x[6:0] == DIGIT_BIAS7) begin
          run_hdr_long = 1'b1;
        end
      end
    end
    if (run_hdr_long) begin
      if (byte_count_r < HDR_CHK) begin
        hsum_hdr = hsum_r + HSUM_W'(c);
      end
      if (byte_count_r == HDR_LEN_HI) begin
        run_hdr = sat_cnt(WIDE_W'(hdr_prod));
      end
      if (byte_count_r == HDR_LEN_LO) begin
        run_hdr = sat_cnt(WIDE_W'(run_r) + WIDE_W'(digit));
      end
    end
  end

  // Next packet state and result
  always_comb begin
    in_packet_nxt  = in_packet_r;
    byte_count_nxt = byte_count_r;
    run_nxt        = run_r;
    long_nxt       = long_r;
    hsum_nxt       = hsum_r;
    ctrlc_nxt      = ctrlc_r;
    res_valid      = 1'b0;
    res            = '0;
    clear          = 1'b0;
    if (item.cmd) begin
      // Host abort
      clear           = 1'b1;
      res_valid       = 1'b1;
      res.result_kind = KIND_FATAL;
    end else if (run_slot) begin
      // Counted run byte: pass through unchecked
      byte_count_nxt  = sat_cnt(WIDE_W'(byte_count_r) + WIDE_W'(1));
      run_nxt         = run_r - CNT_W'(1);
      res_valid       = 1'b1;
      res.result_kind = KIND_DATA;
      res.data_byte   = run_byte;
    end else begin
      run_nxt  = run_hdr;
      long_nxt = run_hdr_long;
      hsum_nxt = hsum_hdr;
      if (run_hdr_long && (byte_count_r == HDR_CHK) && (chk != x)) begin
        run_nxt = '0;
      end
      // Remote control-C run
      if (cfg.remote_mode && (c == CTRL_C)) begin
        if (ctrlc_r == CTRLC_LIMIT) begin
          clear           = 1'b1;
          res_valid       = 1'b1;
          res.result_kind = KIND_FATAL;
        end else begin
          ctrlc_nxt = ctrlc_r + CTRLC_W'(1);
        end
      end else begin
        ctrlc_nxt = '0;
      end
      if (!clear) begin
        if (c == cfg.start_mark) begin
          in_packet_nxt = 1'b1;
        end else if (!in_packet_r) begin
          // hunting: drop the byte
        end else if ((c == cfg.end_mark) || (c == LF_BYTE)) begin
          clear             = 1'b1;
          res_valid         = 1'b1;
          res.result_kind   = KIND_DONE;
          res.packet_length = (bc_wide > CMP_W'(LEN_MAX)) ? LEN_MAX
                                                          : bc_wide[LEN_W-1:0];
        end else if (bc_wide > CMP_W'(cfg.max_length)) begin
          clear           = 1'b1;
          res_valid       = 1'b1;
          res.result_kind = KIND_LONG;
        end else begin
          byte_count_nxt  = sat_cnt(WIDE_W'(byte_count_r) + WIDE_W'(1));
          res_valid       = 1'b1;
          res.result_kind = KIND_DATA;
          res.data_byte   = x;
        end
      end
    end
    if (clear) begin
      in_packet_nxt  = 1'b0;
      byte_count_nxt = '0;
      run_nxt        = '0;
      long_nxt       = 1'b0;
      hsum_nxt       = '0;
      ctrlc_nxt      = '0;
    end
  end

  // State advances once per processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r  <= 1'b0;
      byte_count_r <= '0;
      run_r        <= '0;
      long_r       <= 1'b0;
      hsum_r       <= '0;
      ctrlc_r      <= '0;
    end else if (go) begin
      in_packet_r  <= in_packet_nxt;
      byte_count_r <= byte_count_nxt;
      run_r        <= run_nxt;
      long_r       <= long_nxt;
      hsum_r       <= hsum_nxt;
      ctrlc_r      <= ctrlc_nxt;
    end
  end

endmodule

>>> hw/rtl/kpr_out_reg.sv
// Result register on the output channel.
module kpr_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic               res_valid,
  input  kpr_pkg::out_item_t res,
  output logic               slot_free,
  output logic               out_valid,
  input  logic               out_stall,
  output kpr_pkg::out_item_t out_data
);
  import kpr_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  logic      load;

  // Slot is free when empty or its result transfers this cycle
  assign slot_free = !out_valid_r || !out_stall;
  assign load      = go && res_valid;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

>>> hw/rtl/kermit_packet_receiver_unit.sv
// Kermit packet receiver: finds packets in a received byte stream.
//
// Input channel (in_valid/in_stall/in_data): one item per transfer, either a
// received byte or a host abort request. Output channel (out_valid/out_stall/
// out_data): at most one result per item: a stored packet byte, packet
// complete with its length, too-long error, or fatal abort. Bytes that cause
// no result (hunting, marks, discarded start marks) are consumed silently.
// Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
//
// An item taken into the input register is processed into the result register,
// and its result is on the output from then on. The unit takes one item per
// cycle while the result slot is free; the packet state is updated by a single
// combinational pass between the input register and the result register.
//
// Reset (rst_n low, synchronous) restores the register defaults, returns to
// hunting for the start mark and empties both registers. When out_stall
// holds a result, one more item is taken into the input register, then
// in_stall rises until the result slot frees.
module kermit_packet_receiver_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [kpr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kpr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  kpr_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output kpr_pkg::out_item_t             out_data
);
  import kpr_pkg::*;

  cfg_t      cfg;
  in_item_t  item;
  out_item_t res;
  logic      go, slot_free, res_valid;

  // Configuration registers
  kpr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register
  kpr_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .slot_free (slot_free),
    .go        (go),
    .item      (item)
  );

  // Deframing state and logic
  kpr_deframe u_deframe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .go        (go),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register
  kpr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (go),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the Kermit packet receiver unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kpr_pkg::*;

  localparam int unsigned COUNT_TOP    = (1 << CNT_W) - 1;
  localparam int unsigned QUIET_SLACK  = 6;
  localparam int unsigned WATCHDOG_MAX = 400;
  localparam int unsigned PHASE_ITEMS  = 60;

  // Receiver stall patterns
  localparam int unsigned STALL_NONE     = 0;
  localparam int unsigned STALL_RANDOM   = 1;
  localparam int unsigned STALL_PERIODIC = 2;
  localparam int unsigned STALL_HEAVY    = 3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  kermit_packet_receiver_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #2 clk = ~clk;

  // Register copies (reset values)
  int unsigned m_start  = RST_START_MARK;
  int unsigned m_end    = RST_END_MARK;
  int unsigned m_max    = RST_MAX_LENGTH;
  bit          m_strip  = 1'b0;
  bit          m_remote = 1'b0;

  // Deframer state copy
  bit          f_in_pkt = 1'b0;
  int unsigned f_count  = 0;
  int unsigned f_run    = 0;
  bit          f_long   = 1'b0;
  int unsigned f_sum    = 0;
  int unsigned f_ctrlc  = 0;

  in_item_t  rx_stream_q[$];
  out_item_t deframed_q[$];
  int unsigned mismatches = 0;

  // Driver state
  bit          drv_valid  = 1'b0;
  in_item_t    drv_item   = '0;
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;

  // Receiver stall state
  int unsigned stall_mode = STALL_NONE;
  int unsigned stall_left = 0;
  int unsigned stall_cyc  = 0;

  int unsigned idle_cycles = 0;
  out_item_t   want;

  function automatic int unsigned clamp_cnt(input int unsigned v);
    return (v > COUNT_TOP) ? COUNT_TOP : v;
  endfunction

  function automatic int unsigned len_digit(input int unsigned b);
    return (b < 32) ? 0 : b - 32;
  endfunction

  function automatic int unsigned hdr_check(input int unsigned s);
    return ((s + ((s & 192) >> 6)) & 63) + 32;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic drop_frame();
    f_in_pkt = 1'b0;
    f_count  = 0;
    f_run    = 0;
    f_long   = 1'b0;
    f_sum    = 0;
    f_ctrlc  = 0;
  endtask

  task automatic log_result(input kind_t k, input int unsigned d, input int unsigned len);
    deframed_q.push_back('{result_kind: k, data_byte: 8'(d),
                           packet_length: LEN_W'((len > LEN_MAX) ? LEN_MAX : len)});
  endtask

  // Advance the deframer copy by one accepted item and log what it yields
  task automatic deframe_byte(input in_item_t it);
    int unsigned x, c, v, tmp;
    if (it.cmd) begin
      drop_frame();
      log_result(KIND_FATAL, 0, 0);
      return;
    end
    x = it.rx_byte;
    v = x & 'h7f;
    if (f_in_pkt && f_count == 0) begin
      // LEN slot
      if (v < 32) begin
        f_run = 0;
      end else begin
        f_run = clamp_cnt(v - 32);
        if (f_run == 0) f_long = 1'b1;
      end
    end else if (f_in_pkt && f_run != 0 && f_count != 0 &&
                 !(f_long && f_count < HDR_END)) begin
      // counted run: passed through unchecked
      f_count = clamp_cnt(f_count + 1);
      f_run--;
      log_result(KIND_DATA, m_strip ? v : x, 0);
      return;
    end
    c = m_strip ? v : x;
    // long header fields
    if (f_long) begin
      if (f_count < HDR_CHK) f_sum = (f_sum + c) & 'h7ff;
      if (f_count == HDR_LEN_HI) f_run = clamp_cnt(95 * len_digit(x));
      if (f_count == HDR_LEN_LO) f_run = clamp_cnt(f_run + len_digit(x));
      if (f_count == HDR_CHK && hdr_check(f_sum) != x) f_run = 0;
    end
    if (m_remote && c == CTRL_C) begin
      f_ctrlc++;
      if (f_ctrlc > CTRLC_LIMIT) begin
        drop_frame();
        log_result(KIND_FATAL, 0, 0);
        return;
      end
    end else begin
      f_ctrlc = 0;
    end
    if (!f_in_pkt && c != m_start) return;
    if (c == m_start) begin
      f_in_pkt = 1'b1;
      return;
    end
    if (c == m_end || c == LF_BYTE) begin
      tmp = f_count;
      drop_frame();
      log_result(KIND_DONE, 0, tmp);
      return;
    end
    if (f_count > m_max) begin
      drop_frame();
      log_result(KIND_LONG, 0, 0);
      return;
    end
    f_count = clamp_cnt(f_count + 1);
    log_result(KIND_DATA, x, 0);
  endtask

  // Input driver: pick at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_data);
        drv_valid = 1'b0;
      end
      if (!drv_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (rx_stream_q.size() != 0) begin
          drv_item  = rx_stream_q.pop_front();
          drv_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    in_valid <= drv_valid;
    in_data  <= drv_item;
  end

  // Receiver stall pattern
  always @(negedge clk) begin
    stall_cyc++;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
      stall_left = $urandom_range(20, 120);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 99) < 30);
      STALL_PERIODIC: out_stall <= ((stall_cyc % 7) < 3);
      default:        out_stall <= ($urandom_range(0, 99) < 85);
    endcase
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (deframed_q.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending, kind %0d",
                                out_data.result_kind));
      end else begin
        want = deframed_q.pop_front();
        if (out_data.result_kind !== want.result_kind)
          flag_mismatch($sformatf("result_kind %0d, wanted %0d",
                                  out_data.result_kind, want.result_kind));
        if (out_data.data_byte !== want.data_byte)
          flag_mismatch($sformatf("data_byte %02h, wanted %02h",
                                  out_data.data_byte, want.data_byte));
        if (out_data.packet_length !== want.packet_length)
          flag_mismatch($sformatf("packet_length %0d, wanted %0d",
                                  out_data.packet_length, want.packet_length));
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles > WATCHDOG_MAX) begin
        $display("timeout: no transfer for %0d cycles", idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_byte(input int unsigned b);
    rx_stream_q.push_back('{cmd: 1'b0, rx_byte: 8'(b)});
  endtask

  task automatic send_abort();
    rx_stream_q.push_back('{cmd: 1'b1, rx_byte: 8'($urandom_range(0, 255))});
  endtask

  // Mark byte, sometimes with the parity bit set when it gets stripped
  function automatic int unsigned marked(input int unsigned m);
    if (m_strip && m < 128 && $urandom_range(0, 1) == 1) return m | 'h80;
    return m;
  endfunction

  task automatic send_end();
    if ($urandom_range(0, 3) == 0) send_byte(marked(LF_BYTE));
    else send_byte(marked(m_end));
  endtask

  // Long-packet header with checksum, then its run and terminator, or an abort after a large length
  task automatic send_long(input int unsigned x1, input int unsigned x2, input bit bad);
    int unsigned hdr[5];
    int unsigned s, chk, run;
    hdr[0] = ($urandom_range(0, 1) == 1) ? 'ha0 : 'h20;
    hdr[1] = $urandom_range(32, 126);
    hdr[2] = $urandom_range(65, 90);
    hdr[3] = x1;
    hdr[4] = x2;
    send_byte(marked(m_start));
    s = 0;
    foreach (hdr[i]) begin
      send_byte(hdr[i]);
      s += m_strip ? (hdr[i] & 'h7f) : hdr[i];
    end
    chk = hdr_check(s & 'h7ff);
    if (bad) chk ^= (1 << $urandom_range(0, 4));
    send_byte(chk);
    run = 95 * len_digit(x1) + len_digit(x2);
    if (bad) begin
      repeat ($urandom_range(0, 5)) send_byte($urandom_range(32, 126));
      send_end();
    end else if (run > 200) begin
      // saturated length: a few bytes, then abort
      repeat (3) send_byte($urandom_range(0, 255));
      send_abort();
    end else begin
      repeat (run) send_byte($urandom_range(0, 255));
      send_end();
    end
  endtask

  task automatic send_frame();
    int unsigned r, n, x1;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) send_byte($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 40) begin
      // short packet with a counted run
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 94) : $urandom_range(1, 20);
      send_byte(marked(m_start));
      send_byte((32 + n) | ($urandom_range(0, 1) << 7));
      repeat (n) send_byte($urandom_range(0, 255));
      repeat ($urandom_range(0, 3)) send_byte($urandom_range(32, 126));
      send_end();
    end else if (r < 60) begin
      x1 = ($urandom_range(0, 19) == 0) ? 'hff :
           (($urandom_range(0, 9) == 0) ? 33 : 32);
      send_long(x1, 32 + $urandom_range(0, 30), $urandom_range(0, 9) == 0);
    end else if (r < 72) begin
      // no length: every byte checked against the maximum
      send_byte(marked(m_start));
      send_byte($urandom_range(0, 31));
      n = (m_max < 60 && $urandom_range(0, 1) == 1) ? m_max + 2 : $urandom_range(0, 20);
      repeat (n) send_byte($urandom_range(32, 126));
      send_end();
    end else if (r < 80) begin
      // control-C sequences
      if ($urandom_range(0, 1) == 1) send_byte(marked(m_start));
      n = $urandom_range(1, 4);
      repeat (n) send_byte(marked(CTRL_C));
      if ($urandom_range(0, 1) == 1) begin
        send_byte($urandom_range(32, 126));
        send_byte(marked(CTRL_C));
      end
      send_end();
    end else if (r < 86) begin
      send_byte(marked(m_start));
      send_byte(32 + $urandom_range(0, 30));
      repeat ($urandom_range(0, 4)) send_byte($urandom_range(0, 255));
      send_abort();
    end else begin
      repeat ($urandom_range(1, 4)) send_byte($urandom_range(0, 255));
    end
  endtask

  task automatic put_reg(input cfg_idx_t idx, input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
  endtask

  task automatic set_config(input int unsigned s, input int unsigned e,
                            input int unsigned mx, input bit sp, input bit rm);
    put_reg(CFG_START_MARK, s);
    put_reg(CFG_END_MARK, e);
    put_reg(CFG_MAX_LENGTH, mx);
    put_reg(CFG_STRIP_PARITY, sp);
    put_reg(CFG_REMOTE_MODE, rm);
    @(negedge clk);
    cfg_we   <= 1'b0;
    m_start  = s;
    m_end    = e;
    m_max    = mx;
    m_strip  = sp;
    m_remote = rm;
  endtask

  // Hold the sender until every pending result has been seen
  task automatic wait_quiet();
    while (rx_stream_q.size() != 0 || drv_valid || in_valid || deframed_q.size() != 0)
      @(negedge clk);
    repeat (QUIET_SLACK) @(negedge clk);
  endtask

  task automatic random_phase();
    while (rx_stream_q.size() < PHASE_ITEMS) send_frame();
    wait_quiet();
  endtask

  initial begin
    int unsigned s, e, mx;
    bit sp;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at reset register values
    send_byte('hff);
    send_byte(RST_START_MARK);
    send_byte(RST_START_MARK);
    send_byte('h24);
    send_byte('h00);
    send_byte('hff);
    send_byte(RST_END_MARK);
    send_byte(LF_BYTE);
    send_byte('h41);
    send_byte(RST_END_MARK);
    send_byte(RST_START_MARK);
    send_byte('h1f);
    send_byte(RST_START_MARK);
    send_byte(LF_BYTE);
    send_long('h20, 'h22, 1'b0);
    wait_quiet();

    set_config('h01, 'h0d, 90, 1'b1, 1'b1);
    random_phase();
    set_config('h00, 'hff, 0, 1'b0, 1'b1);
    random_phase();
    set_config('hff, 'h00, 9024, 1'b0, 1'b0);
    random_phase();
    set_config('h7f, 'h00, 5, 1'b1, 1'b0);
    random_phase();

    repeat (3) begin
      sp = $urandom_range(0, 1);
      s  = $urandom_range(0, 255);
      if (sp) s &= 'h7f;
      do e = $urandom_range(0, 255); while (e == s);
      mx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9024) : $urandom_range(0, 30);
      set_config(s, e, mx, sp, $urandom_range(0, 1));
      random_phase();
    end

    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
